### rtl/core/bkc_pkg.sv
// ----------------------------------------------------------------------------
// bkc_pkg
// Shared types and constants of the button and knob conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package bkc_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_LOCK       = 2'd1,
    OP_UNLOCK     = 2'd2,
    OP_TRY_UNLOCK = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HOLD_TICKS     = 3'd0,
    REG_ANALOG_MIN     = 3'd1,
    REG_ANALOG_MAX     = 3'd2,
    REG_FILTER_GAIN    = 3'd3,
    REG_LOCK_THRESHOLD = 3'd4
  } reg_idx_t;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BTN_W     = 2;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned GAIN_W    = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // divider: numerator is (sample - min) * 255, quotient stays below 255
  localparam int unsigned NUM_W = SAMPLE_W + LEVEL_W;
  localparam int unsigned DEN_W = SAMPLE_W;
  localparam int unsigned QUO_W = LEVEL_W;
  localparam int unsigned CNT_W = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [GAIN_W-1:0]  GAIN_FULL  = 9'd256;

  localparam logic [7:0]          HOLD_TICKS_RST     = 8'd15;
  localparam logic [SAMPLE_W-1:0] ANALOG_MIN_RST     = 10'd0;
  localparam logic [SAMPLE_W-1:0] ANALOG_MAX_RST     = 10'd1023;
  localparam logic [GAIN_W-1:0]   FILTER_GAIN_RST    = 9'd26;
  localparam logic [LEVEL_W-1:0]  LOCK_THRESHOLD_RST = 8'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/bkc_ifs.sv
// ----------------------------------------------------------------------------
// bkc interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkc_item_if;
  logic                           valid;
  logic                           ready;
  logic [bkc_pkg::OP_W-1:0]       op;
  logic [bkc_pkg::BTN_W-1:0]      button_levels;
  logic [bkc_pkg::SAMPLE_W-1:0]   analog_sample;

  modport source (output valid, op, button_levels, analog_sample, input ready);
  modport sink   (input valid, op, button_levels, analog_sample, output ready);
endinterface

interface bkc_result_if;
  logic                           valid;
  logic                           ready;
  logic [bkc_pkg::BTN_W-1:0]      press_events;
  logic [bkc_pkg::BTN_W-1:0]      hold_events;
  logic [bkc_pkg::LEVEL_W-1:0]    analog_level;
  logic [bkc_pkg::LEVEL_W-1:0]    filtered_level;
  logic                           locked;

  modport source (output valid, press_events, hold_events, analog_level,
                  filtered_level, locked, input ready);
  modport sink   (input valid, press_events, hold_events, analog_level,
                  filtered_level, locked, output ready);
endinterface

interface bkc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bkc_pkg::CFG_IDX_W-1:0]    index;
  logic [bkc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/bkc_divider.sv
// ----------------------------------------------------------------------------
// bkc_divider
// Restoring divider, one compare and subtract per cycle, one quotient bit
// per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bkc_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [bkc_pkg::NUM_W-1:0]    num,
  input  wire logic [bkc_pkg::DEN_W-1:0]    den,
  output logic      [bkc_pkg::QUO_W-1:0]    quo,
  output bkc_pkg::div_stat_t                stat
);

  localparam int unsigned NW = bkc_pkg::NUM_W;
  localparam int unsigned QW = bkc_pkg::QUO_W;
  localparam int unsigned CW = bkc_pkg::CNT_W;

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && cnt == CW'(QW - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      // divisor aligned to the top quotient bit
      dsh <= NW'({den, {(QW-1){1'b0}}});
      quo <= '0;
      cnt <= '0;
    end else if (stat.busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QW-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/button_and_knob_conditioner.sv
// ----------------------------------------------------------------------------
// button_and_knob_conditioner
// Button press/hold detection, inverse knob mapping with a serial divider,
// exponential level average and knob lock.
// ----------------------------------------------------------------------------
// flow: a tick with sample strictly inside [min,max] runs 8 divider steps,
//   one multiply and one add before the result is valid; a clamped tick
//   skips the divider; lock/unlock/try-unlock go straight to the result
// requests: one request at a time, next request taken the cycle after the
//   result is loaded into the output register
// reset: synchronous; clears button, level and lock state, registers return
//   to their reset values, output register empties
`default_nettype none

module button_and_knob_conditioner #(
  parameter int unsigned NUM_BUTTONS = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  bkc_item_if.sink            item,
  bkc_result_if.source        result,
  bkc_cfg_if.sink             cfg
);

  localparam int unsigned LW   = bkc_pkg::LEVEL_W;
  localparam int unsigned SW   = bkc_pkg::SAMPLE_W;
  localparam int unsigned GW   = bkc_pkg::GAIN_W;
  localparam int unsigned NW   = bkc_pkg::NUM_W;
  localparam int unsigned BW   = bkc_pkg::BTN_W;
  localparam int unsigned LV_N = (NUM_BUTTONS < BW) ? NUM_BUTTONS : BW;
  localparam int unsigned EV_W = (NUM_BUTTONS > BW) ? NUM_BUTTONS : BW;
  localparam int unsigned PW   = 2 * (LW + 1) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SUM  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]    hold_ticks;
  logic [SW-1:0] analog_min;
  logic [SW-1:0] analog_max;
  logic [GW-1:0] filter_gain;
  logic [LW-1:0] lock_threshold;

  // knob state
  logic [LW-1:0] level_now;
  logic [LW-1:0] level_average;
  logic [LW-1:0] level_at_lock;
  logic          lock_flag;

  // button lanes
  logic          press_active [NUM_BUTTONS];
  logic          hold_active  [NUM_BUTTONS];
  logic [7:0]    press_ticks  [NUM_BUTTONS];
  logic          press_active_next [NUM_BUTTONS];
  logic          hold_active_next  [NUM_BUTTONS];
  logic [7:0]    press_ticks_next  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] down;
  logic [EV_W-1:0] press_ev_next;
  logic [EV_W-1:0] hold_ev_next;
  logic [BW-1:0]   press_ev;
  logic [BW-1:0]   hold_ev;

  logic                  item_acc;
  logic                  is_tick;
  logic [SW-1:0]         offset;
  logic [NW-1:0]         offset_w;
  logic [NW-1:0]         div_num;
  logic [SW-1:0]         div_den;
  logic                  div_start;
  logic                  map_full;
  logic                  map_zero;
  logic [bkc_pkg::QUO_W-1:0] div_quo;
  bkc_pkg::div_stat_t    div_stat;

  logic [GW-1:0]         gain_eff;
  logic signed [LW:0]    level_diff;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  avg_sum;
  logic [LW-1:0]         lock_diff;
  logic                  out_free;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign item_acc   = item.valid && item.ready;
  assign is_tick    = (item.op == bkc_pkg::OP_TICK);
  assign out_free   = !result.valid || result.ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks     <= bkc_pkg::HOLD_TICKS_RST;
      analog_min     <= bkc_pkg::ANALOG_MIN_RST;
      analog_max     <= bkc_pkg::ANALOG_MAX_RST;
      filter_gain    <= bkc_pkg::FILTER_GAIN_RST;
      lock_threshold <= bkc_pkg::LOCK_THRESHOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bkc_pkg::REG_HOLD_TICKS:     hold_ticks     <= cfg.data[7:0];
        bkc_pkg::REG_ANALOG_MIN:     analog_min     <= cfg.data[SW-1:0];
        bkc_pkg::REG_ANALOG_MAX:     analog_max     <= cfg.data[SW-1:0];
        bkc_pkg::REG_FILTER_GAIN:    filter_gain    <= cfg.data[GW-1:0];
        bkc_pkg::REG_LOCK_THRESHOLD: lock_threshold <= cfg.data[LW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- button lanes ----------------
  always_comb begin
    down = '0;
    down[LV_N-1:0] = item.button_levels[LV_N-1:0];
  end

  always_comb begin
    press_ev_next = '0;
    hold_ev_next  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      press_active_next[i] = press_active[i];
      hold_active_next[i]  = hold_active[i];
      press_ticks_next[i]  = press_ticks[i];
      if (down[i]) begin
        if (!press_active[i]) begin
          press_ticks_next[i]  = '0;
          press_active_next[i] = 1'b1;
        end else if (press_ticks[i] != 8'hff) begin
          press_ticks_next[i] = press_ticks[i] + 8'd1;
        end
        if (press_ticks_next[i] > hold_ticks && !hold_active[i]) begin
          hold_active_next[i] = 1'b1;
          hold_ev_next[i]     = 1'b1;
        end
      end else if (press_active[i]) begin
        if (hold_active[i]) begin
          hold_active_next[i] = 1'b0;
        end else begin
          press_ev_next[i] = 1'b1;
        end
        press_active_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_active[i] <= 1'b0;
        hold_active[i]  <= 1'b0;
        press_ticks[i]  <= '0;
      end
    end else if (item_acc && is_tick) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_active[i] <= press_active_next[i];
        hold_active[i]  <= hold_active_next[i];
        press_ticks[i]  <= press_ticks_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      press_ev <= is_tick ? press_ev_next[BW-1:0] : '0;
      hold_ev  <= is_tick ? hold_ev_next[BW-1:0]  : '0;
    end
  end

  // ---------------- knob mapping ----------------
  assign map_full = (analog_max <= analog_min) || (item.analog_sample <= analog_min);
  assign map_zero = (item.analog_sample >= analog_max);
  assign offset   = item.analog_sample - analog_min;
  assign offset_w = NW'(offset);
  // times 255 as shift and subtract
  assign div_num  = (offset_w << LW) - offset_w;
  assign div_den  = analog_max - analog_min;
  assign div_start = item_acc && is_tick && !map_full && !map_zero;

  bkc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // average as avg + floor((level - avg) * g / 256)
  assign gain_eff   = (filter_gain > bkc_pkg::GAIN_FULL) ? bkc_pkg::GAIN_FULL : filter_gain;
  assign level_diff = $signed({1'b0, level_now}) - $signed({1'b0, level_average});
  assign avg_sum    = $signed(PW'({1'b0, level_average})) + (prod >>> LW);
  assign lock_diff  = (level_now >= level_at_lock) ? level_now - level_at_lock
                                                   : level_at_lock - level_now;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      level_now     <= '0;
      level_average <= '0;
      level_at_lock <= '0;
      lock_flag     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            unique case (item.op)
              bkc_pkg::OP_TICK: begin
                if (map_full) begin
                  level_now <= bkc_pkg::LEVEL_FULL;
                  state     <= S_MUL;
                end else if (map_zero) begin
                  level_now <= '0;
                  state     <= S_MUL;
                end else begin
                  state <= S_DIV;
                end
              end
              bkc_pkg::OP_LOCK: begin
                level_at_lock <= level_now;
                lock_flag     <= 1'b1;
                state         <= S_DONE;
              end
              bkc_pkg::OP_UNLOCK: begin
                lock_flag <= 1'b0;
                state     <= S_DONE;
              end
              bkc_pkg::OP_TRY_UNLOCK: begin
                if (lock_flag && lock_diff > lock_threshold) begin
                  lock_flag <= 1'b0;
                end
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            level_now <= bkc_pkg::LEVEL_FULL - div_quo;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          level_average <= avg_sum[LW-1:0];
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= level_diff * $signed({1'b0, gain_eff});
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.press_events   <= press_ev;
      result.hold_events    <= hold_ev;
      result.analog_level   <= level_now;
      result.filtered_level <= level_average;
      result.locked         <= lock_flag;
    end
  end

  // ---------------- assertions ----------------
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider running outside the divide phase");

  a_lock_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(lock_flag) |-> $past(item_acc && item.op == bkc_pkg::OP_LOCK))
    else $error("lock set without a lock request");

  a_press_hold_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.press_events & result.hold_events) == '0))
    else $error("press and hold event on the same button");

  a_done_leads_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider result arrived outside the divide phase");

endmodule

`default_nettype wire
